// File: hw/rtl/etl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etl_pkg
// Shared types and codes for the expiring timer list.
// ----------------------------------------------------------------------------
package etl_pkg;

   // request command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam int LevelW   = 3;
   localparam int MessageW = 16;
   localparam int TimeW    = 32;
   localparam int CountOutW = 5;

   typedef struct packed {
      logic [LevelW-1:0]   level;
      logic [MessageW-1:0] message;
      logic [TimeW-1:0]    duration;
      logic [TimeW-1:0]    elapsed;
   } entry_type;

   // per-cell control: move up from the neighbor, or load the write data
   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

// File: hw/rtl/expiring_timer_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// expiring_timer_list
// Ordered table of timed entries kept in a chain of cells.
// ----------------------------------------------------------------------------
// The table lives in a row of CAPACITY cells, live entries packed at the
// front in push order. A push request writes the new entry into the first
// free cell, or is rejected with STATUS_FULL when the table is full, and its
// result is ready the cycle after acceptance. A tick request walks the table
// once as a circular queue: each cycle the head cell's entry is aged by the
// time step in a single saturating adder and compare, every cell takes its
// upper neighbor's entry, and the aged entry is written back at the tail if it
// is still alive or dropped if it expired. A tick steps through accept, one
// visit per live entry, and the result; the single aging unit at the head of
// the chain paces it. One request is worked on at a time; a finished result
// sits in the rsp_ register and a new tick request is taken while it waits,
// a push only once the result register is free.
// ----------------------------------------------------------------------------
module expiring_timer_list #(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [2:0]  req_level,
   input  wire logic [15:0] req_message_id,
   input  wire logic [31:0] req_duration,
   input  wire logic [31:0] req_time_step,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_status,
   output logic [4:0]       rsp_active_count,
   output logic [4:0]       rsp_removed_count
);

   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int WideW = CntW + etl_pkg::CountOutW;

   // control state
   etl_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;       // live entries
   logic [CntW-1:0]    remaining_ff, remaining_in; // entries left to visit
   logic [CntW-1:0]    removed_ff, removed_in;
   logic [31:0]        step_ff, step_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_status_ff, rsp_status_in;
   logic [4:0] rsp_active_ff, rsp_active_in;
   logic [4:0] rsp_removed_ff, rsp_removed_in;

   logic req_accept;
   logic rsp_hold;
   logic load_rsp;
   logic status_sel;

   // chain control
   logic               shift_en;
   logic               wr_en;
   logic [IdxW-1:0]    wr_idx;
   etl_pkg::entry_type wr_data;
   etl_pkg::entry_type push_entry;
   etl_pkg::entry_type aged;
   logic               expired;

   etl_pkg::entry_type     cell_q    [CAPACITY];
   etl_pkg::cell_ctrl_type cell_ctrl [CAPACITY];

   logic [WideW-1:0] active_wide;
   logic [WideW-1:0] removed_wide;

   // ---------------------------------------------------------------
   // Chain of cells: cell i takes cell i+1 on a shift; the top cell
   // takes a blank entry, which never counts as live.
   // ---------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      etl_pkg::entry_type neighbor;

      if (i == CAPACITY - 1) begin : g_top
         assign neighbor = '0;
      end else begin : g_mid
         assign neighbor = cell_q[i+1];
      end

      assign cell_ctrl[i].shift = shift_en;
      assign cell_ctrl[i].write = wr_en && (wr_idx == IdxW'(i));

      etl_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl[i]),
         .neighbor (neighbor),
         .wr_data  (wr_data),
         .entry    (cell_q[i])
      );
   end

   // Age the entry leaving the head of the chain.
   etl_age u_age (
      .head      (cell_q[0]),
      .time_step (step_ff),
      .aged      (aged),
      .expired   (expired)
   );

   // ---------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------
   assign rsp_hold   = rsp_valid_ff && rsp_stall;
   // a push produces its result at once, so it needs a free result register;
   // a tick can start while the previous result still waits
   assign req_stall  = (state_ff != etl_pkg::ST_IDLE) ||
                       ((req_command == etl_pkg::CMD_PUSH) && rsp_hold);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      push_entry.level    = req_level;
      push_entry.message  = req_message_id;
      push_entry.duration = req_duration;
      push_entry.elapsed  = '0;
   end

   // ---------------------------------------------------------------
   // Sequencer: next state, chain control and result loading
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      removed_in   = removed_ff;
      step_in      = step_ff;
      load_rsp     = 1'b0;
      status_sel   = etl_pkg::STATUS_OK;
      shift_en     = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = count_ff[IdxW-1:0];
      wr_data      = push_entry;

      unique case (state_ff)
         etl_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_command == etl_pkg::CMD_PUSH) begin
                  load_rsp = 1'b1;
                  if (count_ff == CntW'(CAPACITY)) begin
                     // table full: reject, leave the chain alone
                     status_sel = etl_pkg::STATUS_FULL;
                  end else begin
                     // append at the first free cell
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  step_in      = req_time_step;
                  remaining_in = count_ff;
                  removed_in   = '0;
                  state_in     = (count_ff == '0) ? etl_pkg::ST_FINISH : etl_pkg::ST_TICK;
               end
            end
         end

         etl_pkg::ST_TICK: begin
            // advance the chain; the aged head returns at the tail if alive
            shift_en     = 1'b1;
            wr_data      = aged;
            wr_idx       = IdxW'(count_ff - 1'b1);
            remaining_in = remaining_ff - 1'b1;
            if (expired) begin
               count_in   = count_ff - 1'b1;
               removed_in = removed_ff + 1'b1;
            end else begin
               wr_en = 1'b1;
            end
            if (remaining_ff == CntW'(1)) begin
               state_in = etl_pkg::ST_FINISH;
            end
         end

         etl_pkg::ST_FINISH: begin
            // wait for the result register, then report the tick
            if (!rsp_hold) begin
               load_rsp = 1'b1;
               state_in = etl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = etl_pkg::ST_IDLE;
         end
      endcase
   end

   // Counts leave on 5 bits; keep the low bits when CAPACITY is wide.
   assign active_wide  = WideW'(count_in);
   assign removed_wide = WideW'(removed_ff);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_active_in  = rsp_active_ff;
      rsp_removed_in = rsp_removed_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_sel;
         rsp_active_in  = active_wide[etl_pkg::CountOutW-1:0];
         rsp_removed_in = (state_ff == etl_pkg::ST_FINISH) ?
                          removed_wide[etl_pkg::CountOutW-1:0] : '0;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etl_pkg::ST_IDLE;
         count_ff     <= '0;
         remaining_ff <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_active_count  = rsp_active_ff;
   assign rsp_removed_count = rsp_removed_ff;

`ifndef SYNTH
   // the live count never exceeds the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("live count above capacity");

   // a tick walk only runs while entries remain to be visited
   a_tick_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff == etl_pkg::ST_TICK) |-> (remaining_ff != '0))
      else $error("tick walk with nothing left");

   // an accepted push into a table with room adds exactly one entry
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_command == etl_pkg::CMD_PUSH) &&
       (count_ff != CntW'(CAPACITY))) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not append");

   // a rejected push reports nothing removed
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == etl_pkg::STATUS_FULL)) |->
      (rsp_removed_ff == '0))
      else $error("full status with removals");

   // during the walk, entries removed plus entries left to visit never exceed the capacity
   a_removed_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == etl_pkg::ST_TICK) |-> (removed_ff + remaining_ff <= CntW'(CAPACITY)))
      else $error("removal count out of range");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/etl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etl_cell
// One slot of the timer chain: hold, take the neighbor's entry, or load.
// ----------------------------------------------------------------------------
module etl_cell (
   input  wire logic                   clock,
   input  wire etl_pkg::cell_ctrl_type ctrl,
   input  wire etl_pkg::entry_type     neighbor,
   input  wire etl_pkg::entry_type     wr_data,
   output etl_pkg::entry_type          entry
);

   etl_pkg::entry_type entry_ff;
   etl_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = neighbor;
      end
      // a write overrides the shift for the tail slot
      if (ctrl.write) begin
         entry_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

// File: hw/rtl/etl_age.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etl_age
// Age the head entry by one time step (saturating) and flag expiry.
// ----------------------------------------------------------------------------
module etl_age (
   input  wire etl_pkg::entry_type          head,
   input  wire logic [etl_pkg::TimeW-1:0]   time_step,
   output etl_pkg::entry_type               aged,
   output logic                             expired
);

   logic [etl_pkg::TimeW:0]   sum;
   logic [etl_pkg::TimeW-1:0] elapsed_sat;

   always_comb begin
      sum         = {1'b0, head.elapsed} + {1'b0, time_step};
      // saturate on carry out
      elapsed_sat = sum[etl_pkg::TimeW] ? '1 : sum[etl_pkg::TimeW-1:0];
      expired     = (elapsed_sat >= head.duration);
      aged         = head;
      aged.elapsed = elapsed_sat;
   end

endmodule
`default_nettype wire
